@@ src/json_string_escaper_top_defines.svh @@
// ---------------------------------------------------------------------------
// JSON string escaper assertion macros
// Shared property forms for the checker that is bound to the top level.
// ---------------------------------------------------------------------------
`ifndef JSON_STRING_ESCAPER_TOP_DEFINES_SVH
`define JSON_STRING_ESCAPER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JSE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/jse_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// JSON string escaper package
// Segment types, character constants and helpers shared by the escaper.
// ---------------------------------------------------------------------------
package jse_pkg;

  localparam int unsigned CAP_W            = 12;
  localparam int unsigned DEF_MAX_CAPACITY = 4095;
  localparam int unsigned DEF_QUEUE_DEPTH  = 4;
  localparam logic [CAP_W-1:0] CAP_RESET   = 12'd255;

  // Characters used by the escape sequences.
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_LF        = 8'h0a;
  localparam logic [7:0] CH_CR        = 8'h0d;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_FF        = 8'h0c;
  localparam logic [7:0] CH_DEL       = 8'h7f;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_DOT       = 8'h2e;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_LOW_N     = 8'h6e;
  localparam logic [7:0] CH_LOW_R     = 8'h72;
  localparam logic [7:0] CH_LOW_T     = 8'h74;
  localparam logic [7:0] CH_LOW_B     = 8'h62;
  localparam logic [7:0] CH_LOW_F     = 8'h66;
  localparam logic [7:0] CH_LOW_U     = 8'h75;

  // Kind of output segment queued from the front end to the back end.
  typedef enum logic [2:0] {
    SEG_PASS,   // one byte, unchanged
    SEG_ESC2,   // backslash plus one escape letter
    SEG_UNI,    // backslash-u-00xx, six bytes
    SEG_DOTS,   // three dots at truncation
    SEG_TERM    // terminating zero, marked last
  } seg_kind_t;

  typedef struct packed {
    seg_kind_t  kind;
    logic [7:0] data;
  } seg_t;

  localparam int unsigned SEG_W = $bits(seg_t);

  // Lower-case hex digit for one nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = CH_ZERO + {4'd0, nib};
    end else begin
      r = 8'h57 + {4'd0, nib};
    end
    return r;
  endfunction

endpackage

@@ src/jse_queue.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// JSE segment queue
// Small first-in first-out buffer between the classifier and the emitter.
// ---------------------------------------------------------------------------
module jse_queue #(
  parameter int unsigned DEPTH = jse_pkg::DEF_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jse_pkg::seg_t push_seg,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output jse_pkg::seg_t head_seg
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  jse_pkg::seg_t   store_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r,  count_nxt;
  logic            do_push, do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_seg   = store_r[rd_ptr_r];

  assign do_push = push && !full;
  assign do_pop  = pop && head_valid;

  // Pointer and fill-count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_seg;
    end
  end

endmodule

@@ src/jse_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// JSE front end
// Accepts input bytes, classifies them, tracks the written count against
// the capacity and queues one segment per byte that produces output.
// ---------------------------------------------------------------------------
module jse_front #(
  parameter int unsigned MAX_CAPACITY = jse_pkg::DEF_MAX_CAPACITY
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [jse_pkg::CAP_W-1:0] cfg_capacity,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_char_byte,
  input  logic                      q_full,
  output logic                      q_push,
  output jse_pkg::seg_t             q_seg
);

  localparam int unsigned CW = jse_pkg::CAP_W;
  localparam int unsigned LW = 17;   // wide enough for any MAX_CAPACITY below 2**17

  logic [CW-1:0] capacity_r;
  logic [CW-1:0] written_r, written_nxt;
  logic          cut_off_r, cut_off_nxt;
  logic [CW-1:0] cap_eff;
  logic [7:0]    esc_char;
  logic [2:0]    seg_len;
  logic [CW:0]   sum_seg, sum_dots;
  logic          accept;
  jse_pkg::seg_t seg_class;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;

  // Capacity clamped to the build-time maximum.
  assign cap_eff = ({{(LW-CW){1'b0}}, capacity_r} > LW'(MAX_CAPACITY)) ?
                   CW'(MAX_CAPACITY) : capacity_r;

  // Two-character escape letter, zero when the byte has none.
  always_comb begin
    case (in_char_byte)
      jse_pkg::CH_QUOTE:     esc_char = jse_pkg::CH_QUOTE;
      jse_pkg::CH_BACKSLASH: esc_char = jse_pkg::CH_BACKSLASH;
      jse_pkg::CH_LF:        esc_char = jse_pkg::CH_LOW_N;
      jse_pkg::CH_CR:        esc_char = jse_pkg::CH_LOW_R;
      jse_pkg::CH_TAB:       esc_char = jse_pkg::CH_LOW_T;
      jse_pkg::CH_BS:        esc_char = jse_pkg::CH_LOW_B;
      jse_pkg::CH_FF:        esc_char = jse_pkg::CH_LOW_F;
      default:               esc_char = jse_pkg::CH_NUL;
    endcase
  end

  // Segment kind and length for a nonzero byte.
  always_comb begin
    if (esc_char != jse_pkg::CH_NUL) begin
      seg_class.kind = jse_pkg::SEG_ESC2;
      seg_class.data = esc_char;
      seg_len        = 3'd2;
    end else if ((in_char_byte < jse_pkg::CH_SPACE) || (in_char_byte == jse_pkg::CH_DEL)) begin
      seg_class.kind = jse_pkg::SEG_UNI;
      seg_class.data = in_char_byte;
      seg_len        = 3'd6;
    end else begin
      seg_class.kind = jse_pkg::SEG_PASS;
      seg_class.data = in_char_byte;
      seg_len        = 3'd1;
    end
  end

  assign sum_seg  = {1'b0, written_r} + {{(CW-2){1'b0}}, seg_len};
  assign sum_dots = {1'b0, written_r} + (CW+1)'(3);

  // Count, truncation and queue push for an accepted byte.
  always_comb begin
    written_nxt = written_r;
    cut_off_nxt = cut_off_r;
    q_push      = 1'b0;
    q_seg       = seg_class;
    if (accept) begin
      if (in_char_byte == jse_pkg::CH_NUL) begin
        q_push      = 1'b1;
        q_seg.kind  = jse_pkg::SEG_TERM;
        q_seg.data  = jse_pkg::CH_NUL;
        written_nxt = '0;
        cut_off_nxt = 1'b0;
      end else if (!cut_off_r) begin
        if (sum_seg > {1'b0, cap_eff}) begin
          cut_off_nxt = 1'b1;
          if (sum_dots <= {1'b0, cap_eff}) begin
            q_push      = 1'b1;
            q_seg.kind  = jse_pkg::SEG_DOTS;
            q_seg.data  = jse_pkg::CH_DOT;
            written_nxt = sum_dots[CW-1:0];
          end
        end else begin
          q_push      = 1'b1;
          written_nxt = sum_seg[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= jse_pkg::CAP_RESET;
      written_r  <= '0;
      cut_off_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity_r <= cfg_capacity;
      end
      written_r <= written_nxt;
      cut_off_r <= cut_off_nxt;
    end
  end

endmodule

@@ src/jse_back.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// JSE back end
// Expands queued segments into escaped bytes, one per cycle while out_ready
// is high, through a registered output stage.
// ---------------------------------------------------------------------------
module jse_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  jse_pkg::seg_t head_seg,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_last_of_string
);

  logic [2:0] idx_r, idx_nxt;
  logic [2:0] last_idx;
  logic [7:0] byte_sel;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       fire;

  assign out_valid          = out_valid_r;
  assign out_byte           = out_byte_r;
  assign out_last_of_string = out_last_r;

  // A new byte moves into the output stage when it is empty or draining.
  assign fire = head_valid && (!out_valid_r || out_ready);
  assign pop  = fire && (idx_r == last_idx);

  // Segment length decode.
  always_comb begin
    unique case (head_seg.kind)
      jse_pkg::SEG_ESC2: last_idx = 3'd1;
      jse_pkg::SEG_UNI:  last_idx = 3'd5;
      jse_pkg::SEG_DOTS: last_idx = 3'd2;
      default:           last_idx = 3'd0;
    endcase
  end

  // Byte at the current position of the segment.
  always_comb begin
    byte_sel = head_seg.data;
    case (head_seg.kind)
      jse_pkg::SEG_ESC2: begin
        byte_sel = (idx_r == 3'd0) ? jse_pkg::CH_BACKSLASH : head_seg.data;
      end
      jse_pkg::SEG_UNI: begin
        case (idx_r)
          3'd0:    byte_sel = jse_pkg::CH_BACKSLASH;
          3'd1:    byte_sel = jse_pkg::CH_LOW_U;
          3'd4:    byte_sel = jse_pkg::hex_digit(head_seg.data[7:4]);
          3'd5:    byte_sel = jse_pkg::hex_digit(head_seg.data[3:0]);
          default: byte_sel = jse_pkg::CH_ZERO;
        endcase
      end
      default: byte_sel = head_seg.data;
    endcase
  end

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (fire) begin
      idx_nxt       = (idx_r == last_idx) ? 3'd0 : idx_r + 3'd1;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload loads only with a transfer into the stage.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte_r <= byte_sel;
      out_last_r <= (head_seg.kind == jse_pkg::SEG_TERM);
    end
  end

endmodule

@@ src/json_string_escaper_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// JSON string escaper
// Turns a zero-terminated byte string into its JSON-escaped form, with
// truncation to a programmable capacity.
// ---------------------------------------------------------------------------
// Channel  | Handshake              | Payload
// ---------+------------------------+----------------------------------------
// cfg      | cfg_valid / cfg_ready  | cfg_capacity[11:0]
// in       | in_valid / in_ready    | in_char_byte[7:0]
// out      | out_valid / out_ready  | out_byte[7:0], out_last_of_string
//
// The front end takes one input byte per cycle while the segment queue has
// room; the back end emits one byte per cycle while out_ready is high, so
// an input byte becomes one, two or six output bytes (six for a backslash-u
// escape), a truncation mark three. The first output byte passes the segment
// queue and then the registered output stage. Reset (rst_n low, synchronous)
// sets capacity to 255 and clears control state, not queue storage or
// output payload. Stalls on out back up through the queue to in_ready.
// ---------------------------------------------------------------------------
module json_string_escaper_top #(
  parameter int unsigned MAX_CAPACITY = jse_pkg::DEF_MAX_CAPACITY,
  parameter int unsigned QUEUE_DEPTH  = jse_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [jse_pkg::CAP_W-1:0] cfg_capacity,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_char_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_byte,
  output logic                      out_last_of_string
);

  logic          q_full, q_push, q_pop, q_head_valid;
  jse_pkg::seg_t q_push_seg, q_head_seg;

  jse_front #(
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_capacity (cfg_capacity),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_byte (in_char_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_seg        (q_push_seg)
  );

  jse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_seg   (q_push_seg),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_seg   (q_head_seg)
  );

  jse_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head_valid         (q_head_valid),
    .head_seg           (q_head_seg),
    .pop                (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .out_last_of_string (out_last_of_string)
  );

endmodule

@@ src/jse_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// JSE port checker
// Watches the top-level ports of the escaper and flags illegal sequences.
// ---------------------------------------------------------------------------
`include "json_string_escaper_top_defines.svh"

module jse_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last_of_string
);

  // A stalled output transfer keeps its valid and payload.
  `JSE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last_of_string), "output changed while stalled")

  // The end-of-string marker only travels with a zero byte.
  `JSE_ASSERT_NOW(a_last_is_zero, clk, rst_n, out_valid && out_last_of_string, out_byte == 8'h00, "last marker on a nonzero byte")

  // Escaped text never contains a zero byte except the terminator.
  `JSE_ASSERT_NOW(a_zero_is_last, clk, rst_n, out_valid && (out_byte == 8'h00), out_last_of_string, "zero byte inside escaped text")

endmodule

bind json_string_escaper_top jse_checker u_jse_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_byte           (out_byte),
  .out_last_of_string (out_last_of_string)
);
